// ----- rtl/core/ttcc_pkg.sv -----
// Shared constants for the text terminal cursor control block.
// Field widths, character codes, command codes and register indexes.
// No dependencies.
package ttcc_pkg;

  localparam int CHAR_W     = 8;
  localparam int COLOUR_W   = 24;
  localparam int ORIGIN_W   = 12;
  localparam int PIX_W      = 13;
  localparam int POS_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_BACKSP   = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_DELETE   = 8'h7F;
  localparam logic [CHAR_W-1:0] CODE_PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] CODE_PRINT_HI = 8'd126;
  localparam logic [CHAR_W-1:0] GLYPH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] GLYPH_NONE    = 8'd0;

  localparam logic ACT_DRAW   = 1'b0;
  localparam logic ACT_SCROLL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND   = 3'd4;

  localparam logic [POS_W-1:0]    RST_COLUMN_COUNT = 8'd78;
  localparam logic [POS_W-1:0]    RST_ROW_COUNT    = 8'd22;
  localparam logic [ORIGIN_W-1:0] RST_ORIGIN_X     = 12'd88;
  localparam logic [ORIGIN_W-1:0] RST_ORIGIN_Y     = 12'd88;
  localparam logic [COLOUR_W-1:0] RST_BACKGROUND   = 24'd987418;

endpackage

// ----- rtl/core/ttcc_if.sv -----
// Handshake channels of the text terminal cursor control block.
// Character items in, drawing command items out. Depends on ttcc_pkg.
interface ttcc_char_if import ttcc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOUR_W-1:0] fore_colour;

  modport source (output valid, char_code, fore_colour, input ready);
  modport sink   (input valid, char_code, fore_colour, output ready);
endinterface

interface ttcc_cmd_if import ttcc_pkg::*;;
  logic                valid;
  logic                ready;
  logic                action;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;
  logic [CHAR_W-1:0]   glyph;
  logic [COLOUR_W-1:0] draw_colour;
  logic [COLOUR_W-1:0] fill_colour;
  logic                last;

  modport source (output valid, action, pixel_x, pixel_y, glyph, draw_colour,
                  fill_colour, last, input ready);
  modport sink   (input valid, action, pixel_x, pixel_y, glyph, draw_colour,
                  fill_colour, last, output ready);
endinterface

// ----- rtl/core/text_terminal_cursor_control.sv -----
// Text terminal cursor control: cursor tracking and draw/scroll command issue.
// Depends on ttcc_pkg and the channel interfaces in ttcc_if.sv.
//
// Each character item is taken into an input register; from there one pass of
// logic updates the cursor and loads a two-slot result register (a scroll
// slot and a draw slot). Newline, backspace/delete and printable codes 32..126
// act; other codes are dropped without output. An item that yields no command
// or one command frees the result register as soon as that command leaves, so
// a new character can be taken every cycle while the output side keeps up; an
// item that yields a scroll plus a draw holds the single output port for both
// commands, scroll first. An accepted item waits in the input register until
// the result register is free. Registers are written through the cfg port
// and must only change while the block is idle.
module text_terminal_cursor_control import ttcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ttcc_char_if.sink             chars,
  ttcc_cmd_if.source            cmds
);

  // configuration
  logic [POS_W-1:0]    column_count;
  logic [POS_W-1:0]    row_count;
  logic [ORIGIN_W-1:0] origin_x;
  logic [ORIGIN_W-1:0] origin_y;
  logic [COLOUR_W-1:0] background_colour;

  // cursor
  logic [POS_W-1:0] cursor_column;
  logic [POS_W-1:0] cursor_row;

  // input register
  logic                in_vld;
  logic [CHAR_W-1:0]   in_code;
  logic [COLOUR_W-1:0] in_fore;

  // result slots: 0 holds a scroll, 1 holds a draw
  logic                scr_vld;
  logic                scr_last;
  logic [PIX_W-1:0]    scr_x;
  logic [PIX_W-1:0]    scr_y;
  logic [COLOUR_W-1:0] scr_fill;
  logic                drw_vld;
  logic [PIX_W-1:0]    drw_x;
  logic [PIX_W-1:0]    drw_y;
  logic [CHAR_W-1:0]   drw_glyph;
  logic [COLOUR_W-1:0] drw_colour;
  logic [COLOUR_W-1:0] drw_fill;

  logic out_fire;
  logic slots_free;
  logic move;

  // decode and cursor logic
  logic             is_nl;
  logic             is_bs;
  logic             is_pr;
  logic             need_wrap;
  logic [POS_W-1:0] rows_eff;
  logic [POS_W:0]   row_inc;
  logic             row_over;
  logic [POS_W-1:0] row_nl;
  logic             do_scroll;
  logic             do_draw;
  logic [POS_W-1:0] draw_col;
  logic [POS_W-1:0] draw_row;
  logic [POS_W-1:0] cursor_column_next;
  logic [POS_W-1:0] cursor_row_next;

  always_comb begin
    is_nl     = (in_code == CODE_NEWLINE);
    is_bs     = (in_code == CODE_BACKSP) || (in_code == CODE_DELETE);
    is_pr     = (in_code >= CODE_PRINT_LO) && (in_code <= CODE_PRINT_HI);
    need_wrap = is_pr && (cursor_column >= column_count);

    // a row count of zero behaves as one row
    rows_eff = (row_count == '0) ? POS_W'(1) : row_count;
    row_inc  = {1'b0, cursor_row} + (POS_W+1)'(1);
    row_over = (row_inc >= {1'b0, rows_eff});
    row_nl   = row_over ? (rows_eff - POS_W'(1)) : row_inc[POS_W-1:0];

    do_scroll = (is_nl || need_wrap) && row_over;
    do_draw   = (is_bs && (cursor_column != '0)) || is_pr;

    draw_col = cursor_column;
    draw_row = cursor_row;
    if (is_bs) begin
      draw_col = cursor_column - POS_W'(1);
    end else if (need_wrap) begin
      draw_col = '0;
      draw_row = row_nl;
    end

    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    if (is_nl) begin
      cursor_column_next = '0;
      cursor_row_next    = row_nl;
    end else if (is_bs && (cursor_column != '0)) begin
      cursor_column_next = draw_col;
    end else if (is_pr) begin
      cursor_column_next = draw_col + POS_W'(1);
      cursor_row_next    = draw_row;
    end
  end

  assign out_fire   = cmds.valid && cmds.ready;
  // slots can be reloaded when empty or when the only pending command leaves now
  assign slots_free = !(scr_vld || drw_vld) || (out_fire && !(scr_vld && drw_vld));
  assign move       = in_vld && slots_free;
  assign chars.ready = !in_vld || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= RST_COLUMN_COUNT;
      row_count         <= RST_ROW_COUNT;
      origin_x          <= RST_ORIGIN_X;
      origin_y          <= RST_ORIGIN_Y;
      background_colour <= RST_BACKGROUND;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT: column_count      <= cfg_data[POS_W-1:0];
        REG_ROW_COUNT:    row_count         <= cfg_data[POS_W-1:0];
        REG_ORIGIN_X:     origin_x          <= cfg_data[ORIGIN_W-1:0];
        REG_ORIGIN_Y:     origin_y          <= cfg_data[ORIGIN_W-1:0];
        REG_BACKGROUND:   background_colour <= cfg_data[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (chars.ready) begin
      in_vld <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_code <= chars.char_code;
      in_fore <= chars.fore_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      scr_vld       <= 1'b0;
      drw_vld       <= 1'b0;
    end else if (move) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      scr_vld       <= do_scroll;
      drw_vld       <= do_draw;
    end else if (out_fire) begin
      // drain the scroll slot first
      if (scr_vld) begin
        scr_vld <= 1'b0;
      end else begin
        drw_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      scr_last   <= is_nl;
      scr_x      <= {1'b0, origin_x};
      scr_y      <= {1'b0, origin_y};
      scr_fill   <= background_colour;
      drw_x      <= {1'b0, origin_x} + {2'b00, draw_col, 3'b000};
      drw_y      <= {1'b0, origin_y} + {1'b0, draw_row, 4'b0000};
      drw_glyph  <= is_bs ? GLYPH_SPACE : in_code;
      drw_colour <= in_fore;
      drw_fill   <= background_colour;
    end
  end

  assign cmds.valid       = scr_vld || drw_vld;
  assign cmds.action      = scr_vld ? ACT_SCROLL : ACT_DRAW;
  assign cmds.pixel_x     = scr_vld ? scr_x : drw_x;
  assign cmds.pixel_y     = scr_vld ? scr_y : drw_y;
  assign cmds.glyph       = scr_vld ? GLYPH_NONE : drw_glyph;
  assign cmds.draw_colour = scr_vld ? '0 : drw_colour;
  assign cmds.fill_colour = scr_vld ? scr_fill : drw_fill;
  assign cmds.last        = scr_vld ? scr_last : 1'b1;

  // a scroll that is not the final command must have its draw queued behind it
  a_scroll_then_draw: assert property (@(posedge clk) disable iff (rst)
    (scr_vld && !scr_last) |-> drw_vld)
    else $error("scroll without following draw");

  // after a scroll the cursor sits on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (move && do_scroll) |=> (cursor_row == $past(rows_eff - POS_W'(1))))
    else $error("cursor row wrong after scroll");

  // ignored codes leave the cursor alone
  a_ignored_stable: assert property (@(posedge clk) disable iff (rst)
    (move && !is_nl && !is_bs && !is_pr) |=>
      ($stable(cursor_column) && $stable(cursor_row)))
    else $error("ignored code moved cursor");

  // a pending scroll is never lost without being delivered
  a_scroll_held: assert property (@(posedge clk) disable iff (rst)
    (scr_vld && !cmds.ready) |=> scr_vld)
    else $error("scroll dropped while stalled");

endmodule

// ----- dv/text_terminal_cursor_control_test.sv -----
// Testbench for text_terminal_cursor_control: character items in, draw/scroll
// commands out. A cursor predictor runs next to the block, and each command is
// checked in order. Depends on ttcc_pkg, ttcc_if.sv and the block itself.
`timescale 1ns / 1ps

module text_terminal_cursor_control_test;
  import ttcc_pkg::*;

  localparam int IDLE_LIMIT      = 3000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 1100;
  localparam int REPORT_LIMIT    = 50;

  localparam logic [CHAR_W-1:0] CODE_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_NUL        = 8'h00;
  localparam logic [CHAR_W-1:0] CODE_UNIT_SEP   = 8'h1F;
  localparam logic [CHAR_W-1:0] CODE_HIGH_FIRST = 8'h80;
  localparam logic [CHAR_W-1:0] CODE_HIGH_LAST  = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_BACKGROUND + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  typedef struct packed {
    logic                action;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [CHAR_W-1:0]   glyph;
    logic [COLOUR_W-1:0] draw_colour;
    logic [COLOUR_W-1:0] fill_colour;
    logic                last;
  } term_cmd_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ttcc_char_if char_bus ();
  ttcc_cmd_if  cmd_bus ();

  text_terminal_cursor_control DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chars     (char_bus),
    .cmds      (cmd_bus)
  );

  always #5 clk = ~clk;

  // Predicted terminal state
  logic [POS_W-1:0]    area_cols;
  logic [POS_W-1:0]    area_rows;
  logic [ORIGIN_W-1:0] area_org_x;
  logic [ORIGIN_W-1:0] area_org_y;
  logic [COLOUR_W-1:0] area_fill;
  logic [POS_W-1:0]    cursor_col;
  logic [POS_W-1:0]    cursor_row;

  term_cmd_t pending_cmds[$];

  int          burst_left;
  int          rx_hold_off;
  int          idle_cycles;
  int unsigned items_sent;
  int unsigned acting_items;
  int unsigned reg_writes;
  int unsigned scrolls_seen;
  int unsigned draws_seen;
  int unsigned mismatches;

  // Move to column 0 of the next row; returns 1 when the area has to scroll.
  function automatic bit advance_line();
    logic [POS_W:0] rows;
    logic [POS_W:0] nxt;
    rows = (area_rows == '0) ? 9'd1 : {1'b0, area_rows};
    nxt = {1'b0, cursor_row} + 9'd1;
    cursor_col = '0;
    if (nxt >= rows) begin
      cursor_row = rows[POS_W-1:0] - 8'd1;
      return 1'b1;
    end
    cursor_row = nxt[POS_W-1:0];
    return 1'b0;
  endfunction

  function automatic term_cmd_t scroll_cmd(input logic is_last);
    term_cmd_t c;
    c.action      = ACT_SCROLL;
    c.pixel_x     = PIX_W'(area_org_x);
    c.pixel_y     = PIX_W'(area_org_y);
    c.glyph       = GLYPH_NONE;
    c.draw_colour = '0;
    c.fill_colour = area_fill;
    c.last        = is_last;
    return c;
  endfunction

  function automatic term_cmd_t cell_cmd(input logic [CHAR_W-1:0] g,
                                         input logic [COLOUR_W-1:0] fg);
    term_cmd_t c;
    c.action      = ACT_DRAW;
    c.pixel_x     = PIX_W'(area_org_x) + PIX_W'(cursor_col) * 13'd8;
    c.pixel_y     = PIX_W'(area_org_y) + PIX_W'(cursor_row) * 13'd16;
    c.glyph       = g;
    c.draw_colour = fg;
    c.fill_colour = area_fill;
    c.last        = 1'b1;
    return c;
  endfunction

  function automatic void predict_commands(input logic [CHAR_W-1:0] code,
                                           input logic [COLOUR_W-1:0] fg);
    if (code == CODE_NEWLINE) begin
      acting_items++;
      if (advance_line()) pending_cmds.push_back(scroll_cmd(1'b1));
    end else if (code == CODE_BACKSP || code == CODE_DELETE) begin
      if (cursor_col != '0) begin
        acting_items++;
        cursor_col = cursor_col - 8'd1;
        pending_cmds.push_back(cell_cmd(GLYPH_SPACE, fg));
      end
    end else if (code >= CODE_PRINT_LO && code <= CODE_PRINT_HI) begin
      acting_items++;
      if (cursor_col >= area_cols) begin
        if (advance_line()) pending_cmds.push_back(scroll_cmd(1'b0));
      end
      pending_cmds.push_back(cell_cmd(code, fg));
      cursor_col = cursor_col + 8'd1;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, name, want, got);
    end
  endfunction

  function automatic void check_command();
    term_cmd_t want;
    if (pending_cmds.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display({"%0t: command with nothing expected, expected none, ",
                  "actual action %0h x %0h y %0h glyph %0h"},
                 $time, cmd_bus.action, cmd_bus.pixel_x, cmd_bus.pixel_y,
                 cmd_bus.glyph);
      return;
    end
    want = pending_cmds.pop_front();
    if (want.action == ACT_SCROLL) scrolls_seen++;
    else draws_seen++;
    compare_field("action", 32'(want.action), 32'(cmd_bus.action));
    compare_field("pixel_x", 32'(want.pixel_x), 32'(cmd_bus.pixel_x));
    compare_field("pixel_y", 32'(want.pixel_y), 32'(cmd_bus.pixel_y));
    compare_field("glyph", 32'(want.glyph), 32'(cmd_bus.glyph));
    compare_field("draw_colour", 32'(want.draw_colour), 32'(cmd_bus.draw_colour));
    compare_field("fill_colour", 32'(want.fill_colour), 32'(cmd_bus.fill_colour));
    compare_field("last", 32'(want.last), 32'(cmd_bus.last));
  endfunction

  always @(posedge clk) begin
    if (!rst && cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) check_command();
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((char_bus.valid === 1'b1 && char_bus.ready === 1'b1) ||
                 (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles, %0d commands outstanding",
                 $time, IDLE_LIMIT, pending_cmds.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: runs of ready and stalls of random length, rare long free runs,
  // and a forced hold-off whenever a test asks for one.
  initial begin : rx_pattern
    int  run;
    bit  level;
    cmd_bus.ready = 1'b0;
    run = 0;
    level = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (rx_hold_off > 0) begin
        cmd_bus.ready <= 1'b0;
        rx_hold_off--;
      end else begin
        if (run == 0) begin
          level = !level;
          if (level) run = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
          else run = $urandom_range(1, 6);
        end
        cmd_bus.ready <= level;
        run--;
      end
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following item keeps it up without a glitch.
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic [COLOUR_W-1:0] fg);
    char_bus.valid       <= 1'b1;
    char_bus.char_code   <= code;
    char_bus.fore_colour <= fg;
    @(posedge clk);
    while (char_bus.ready !== 1'b1) @(posedge clk);
    predict_commands(code, fg);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_paced(input logic [CHAR_W-1:0] code, input logic [COLOUR_W-1:0] fg);
    send_char(code, fg);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      char_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 23);
    end
  endtask

  task automatic drain_commands();
    char_bus.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    reg_writes++;
    case (idx)
      REG_COLUMN_COUNT: area_cols  = data[POS_W-1:0];
      REG_ROW_COUNT:    area_rows  = data[POS_W-1:0];
      REG_ORIGIN_X:     area_org_x = data[ORIGIN_W-1:0];
      REG_ORIGIN_Y:     area_org_y = data[ORIGIN_W-1:0];
      REG_BACKGROUND:   area_fill  = data[COLOUR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 62) return CHAR_W'($urandom_range(CODE_PRINT_LO, CODE_PRINT_HI));
    if (r < 75) return CODE_NEWLINE;
    if (r < 87) return $urandom_range(0, 1) ? CODE_BACKSP : CODE_DELETE;
    return CHAR_W'($urandom);
  endfunction

  // Small sizes dominate so wraps and scrolls come often
  function automatic logic [POS_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r < 5) return 8'd1;
    if (r < 14) return POS_W'($urandom_range(2, 12));
    if (r < 17) return POS_W'($urandom);
    return '1;
  endfunction

  function automatic logic [ORIGIN_W-1:0] pick_origin();
    int unsigned r;
    r = $urandom_range(0, 4);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ORIGIN_W'($urandom);
  endfunction

  task automatic randomize_area();
    if ($urandom_range(0, 2) == 0)
      write_config(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                   CFG_DATA_W'($urandom));
    if ($urandom_range(0, 3) != 0)
      write_config(REG_COLUMN_COUNT, {16'($urandom), pick_count()});
    if ($urandom_range(0, 3) != 0)
      write_config(REG_ROW_COUNT, {16'($urandom), pick_count()});
    if ($urandom_range(0, 1) != 0)
      write_config(REG_ORIGIN_X, {12'($urandom), pick_origin()});
    if ($urandom_range(0, 1) != 0)
      write_config(REG_ORIGIN_Y, {12'($urandom), pick_origin()});
    if ($urandom_range(0, 1) != 0)
      write_config(REG_BACKGROUND, CFG_DATA_W'($urandom));
  endtask

  // Reset area: extremes of both fields, every code class, ignored bytes
  task automatic test_basic_codes();
    send_char(CODE_BACKSP, 24'h0F0F0F);      // column 0: nothing to erase
    send_char(CODE_PRINT_LO, 24'h000000);
    send_char(CODE_PRINT_HI, 24'hFFFFFF);
    send_char(CODE_DELETE, 24'h123456);
    send_char(CODE_BACKSP, 24'hEDCBA9);
    send_char(CODE_CR, 24'hFFFFFF);
    send_char(CODE_NUL, 24'h000000);
    send_char(CODE_HIGH_LAST, 24'hAAAAAA);
    send_char(CODE_UNIT_SEP, 24'h555555);
    send_char(CODE_HIGH_FIRST, 24'hFFFFFF);
    send_char("A", 24'($urandom));
    send_char(CODE_NEWLINE, 24'h000000);     // next row, no command
  endtask

  task automatic test_wrap_and_scroll();
    drain_commands();
    // upper data bits must not reach the narrow registers
    write_config(REG_COLUMN_COUNT, 24'hFFFF02);
    write_config(REG_ROW_COUNT, 24'hA5A501);
    write_config(REG_ORIGIN_X, 24'hFFF000);
    write_config(REG_ORIGIN_Y, 24'h000FFF);
    write_config(REG_BACKGROUND, 24'h000000);
    // cursor sits on row 1, past the single row left
    send_char(CODE_NEWLINE, 24'($urandom));
    send_char("a", 24'($urandom));
    send_char("b", 24'($urandom));
    send_char("c", 24'($urandom));
    send_char(CODE_NEWLINE, 24'($urandom));
    drain_commands();
    // zero counts: every printable wraps, every newline scrolls
    write_config(REG_COLUMN_COUNT, 24'd0);
    write_config(REG_ROW_COUNT, 24'd0);
    send_char("x", 24'($urandom));
    send_char("y", 24'($urandom));
    send_char(CODE_NEWLINE, 24'($urandom));
    drain_commands();
    write_config(REG_COLUMN_COUNT, 24'd255);
    write_config(REG_ROW_COUNT, 24'd255);
    write_config(REG_BACKGROUND, 24'hFFFFFF);
    send_char("p", 24'($urandom));
    send_char(CODE_NEWLINE, 24'($urandom));
    send_char(CODE_NEWLINE, 24'($urandom));
    send_char("r", 24'($urandom));
    drain_commands();
    // shrink the area under the cursor
    write_config(REG_UNUSED_FIRST, 24'h3C3C3C);
    write_config(REG_UNUSED_LAST, 24'hC3C3C3);
    write_config(REG_COLUMN_COUNT, 24'd1);
    write_config(REG_ROW_COUNT, 24'd2);
    send_char("s", 24'($urandom));
    send_char("t", 24'($urandom));
    send_char(CODE_NEWLINE, 24'($urandom));
    drain_commands();
  endtask

  // Largest area at the far corner: walk the whole row, then every row
  task automatic test_full_area();
    write_config(REG_COLUMN_COUNT, 24'h5A5AFF);
    write_config(REG_ROW_COUNT, 24'hA5A5FF);
    write_config(REG_ORIGIN_X, 24'h000FFF);
    write_config(REG_ORIGIN_Y, 24'hFFFFFF);
    write_config(REG_BACKGROUND, 24'($urandom));
    send_paced(CODE_NEWLINE, 24'($urandom));
    repeat (257) send_paced(CHAR_W'($urandom_range(CODE_PRINT_LO, CODE_PRINT_HI)),
                            24'($urandom));
    repeat (256) send_paced(CODE_NEWLINE, 24'($urandom));
    drain_commands();
  endtask

  // Receiver holds off while the sender keeps offering, then drain fully
  task automatic test_receiver_hold_off();
    write_config(REG_COLUMN_COUNT, 24'd4);
    write_config(REG_ROW_COUNT, 24'd3);
    write_config(REG_ORIGIN_X, 24'd16);
    write_config(REG_ORIGIN_Y, 24'd32);
    rx_hold_off = HOLD_OFF_CYCLES;
    repeat (48) send_char(CHAR_W'($urandom_range(CODE_PRINT_LO, CODE_PRINT_HI)),
                          24'($urandom));
    drain_commands();
  endtask

  task automatic test_random_phases();
    int unsigned start;
    start = acting_items;
    while (acting_items - start < RANDOM_ITEMS) begin
      drain_commands();
      randomize_area();
      repeat ($urandom_range(20, 120)) send_paced(pick_char(), 24'($urandom));
    end
    drain_commands();
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    char_bus.valid       = 1'b0;
    char_bus.char_code   = '0;
    char_bus.fore_colour = '0;
    area_cols            = RST_COLUMN_COUNT;
    area_rows            = RST_ROW_COUNT;
    area_org_x           = RST_ORIGIN_X;
    area_org_y           = RST_ORIGIN_Y;
    area_fill            = RST_BACKGROUND;
    cursor_col           = '0;
    cursor_row           = '0;
    burst_left           = 0;
    rx_hold_off          = 0;
    items_sent           = 0;
    acting_items         = 0;
    reg_writes           = 0;
    scrolls_seen         = 0;
    draws_seen           = 0;
    mismatches           = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_codes();
    test_wrap_and_scroll();
    test_full_area();
    test_receiver_hold_off();
    test_random_phases();

    $display("Sent %0d character items (%0d acting) over %0d register writes.",
             items_sent, acting_items, reg_writes);
    $display("Checked %0d draw and %0d scroll commands, %0d mismatches.",
             draws_seen, scrolls_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
